// ----- rtl/b64sc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types, constants and alphabet functions
// Result-group type between the front and back ends, alphabet characters,
// register indexes and the value/character mapping functions.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ALT_ALPHABET = 2'd1;

  // Default depth of the group queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Alphabet characters
  localparam logic [7:0] STD_PAD = 8'h3D;  // '='
  localparam logic [7:0] ALT_PAD = 8'h2D;  // '-'
  localparam logic [7:0] STD_C62 = 8'h2B;  // '+'
  localparam logic [7:0] STD_C63 = 8'h2F;  // '/'
  localparam logic [7:0] ALT_C62 = 8'h5F;  // '_'
  localparam logic [7:0] ALT_C63 = 8'h2E;  // '.'

  // One group of results caused by one input beat.
  // bytes[0] goes out first; cnt is the number of results minus one.
  // last/err apply to the final result of the group only.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
    logic            err;
  } job_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] char_of(input logic [5:0] v, input logic alt);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return 8'h41 + w;
    else if (v < 6'd52) return 8'h61 + w - 8'd26;
    else if (v < 6'd62) return 8'h30 + w - 8'd52;
    else if (v == 6'd62) return alt ? ALT_C62 : STD_C62;
    else                return alt ? ALT_C63 : STD_C63;
  endfunction

  // Character to {invalid, value}
  function automatic logic [6:0] value_of(input logic [7:0] c, input logic alt);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      return {1'b0, d[5:0]};
    end else if (c == (alt ? ALT_C62 : STD_C62)) begin
      return 7'd62;
    end else if (c == (alt ? ALT_C63 : STD_C63)) begin
      return 7'd63;
    end
    return 7'd64;
  endfunction

endpackage

// ----- rtl/b64sc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_front: beat intake and group builder
// Holds the mode registers and the per-message state, and turns each
// accepted beat into zero or one result group for the queue.
// ----------------------------------------------------------------------------
module b64sc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [b64sc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic                            cfg_data,
  input  logic                            accept,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  output logic                            push,
  output b64sc_pkg::job_t                 job
);

  logic        direction_r, alt_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic        twp_r, twp_nxt;
  logic        failed_r, failed_nxt;

  logic [7:0]  pad;
  logic        is_pad;
  logic [6:0]  val;
  logic [7:0]  prev;
  logic [23:0] shifted;

  always_comb begin
    pad         = alt_r ? b64sc_pkg::ALT_PAD : b64sc_pkg::STD_PAD;
    is_pad      = (in_byte == pad);
    val         = is_pad ? 7'd0 : b64sc_pkg::value_of(in_byte, alt_r);
    prev        = partial_r[7:0];
    shifted     = {partial_r[17:0], val[5:0]};
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    twp_nxt     = twp_r;
    failed_nxt  = failed_r;
    push        = 1'b0;
    job         = '0;

    if (accept) begin
      if (!direction_r) begin
        // encode: a character goes out as soon as its six bits are known
        push = 1'b1;
        if (phase_r == 2'd1) begin
          job.bytes[0] = b64sc_pkg::char_of({prev[1:0], in_byte[7:4]}, alt_r);
          if (in_last) begin
            job.bytes[1] = b64sc_pkg::char_of({in_byte[3:0], 2'b00}, alt_r);
            job.bytes[2] = pad;
            job.cnt      = 2'd2;
            job.last     = 1'b1;
            phase_nxt    = 2'd0;
            partial_nxt  = '0;
          end else begin
            partial_nxt = {16'h0000, in_byte};
            phase_nxt   = 2'd2;
          end
        end else if (phase_r == 2'd2) begin
          job.bytes[0] = b64sc_pkg::char_of({prev[3:0], in_byte[7:6]}, alt_r);
          job.bytes[1] = b64sc_pkg::char_of(in_byte[5:0], alt_r);
          job.cnt      = 2'd1;
          job.last     = in_last;
          phase_nxt    = 2'd0;
          partial_nxt  = '0;
        end else begin
          job.bytes[0] = b64sc_pkg::char_of(in_byte[7:2], alt_r);
          if (in_last) begin
            job.bytes[1] = b64sc_pkg::char_of({in_byte[1:0], 4'b0000}, alt_r);
            job.bytes[2] = pad;
            job.bytes[3] = pad;
            job.cnt      = 2'd3;
            job.last     = 1'b1;
            phase_nxt    = 2'd0;
            partial_nxt  = '0;
          end else begin
            partial_nxt = {16'h0000, in_byte};
            phase_nxt   = 2'd1;
          end
        end
      end else if (failed_r) begin
        // skipping the rest of a failed message
        if (in_last) begin
          failed_nxt  = 1'b0;
          phase_nxt   = 2'd0;
          partial_nxt = '0;
          twp_nxt     = 1'b0;
        end
      end else if (val[6] || (phase_r != 2'd3 && in_last)) begin
        // bad character or early end: one error result
        push        = 1'b1;
        job.cnt     = 2'd0;
        job.last    = 1'b1;
        job.err     = 1'b1;
        phase_nxt   = 2'd0;
        partial_nxt = '0;
        twp_nxt     = 1'b0;
        failed_nxt  = !in_last;
      end else if (phase_r != 2'd3) begin
        partial_nxt = shifted;
        if (phase_r == 2'd2) twp_nxt = is_pad;
        phase_nxt = phase_r + 2'd1;
      end else begin
        // quartet complete; final pads trim the tail
        push         = 1'b1;
        job.bytes[0] = shifted[23:16];
        job.bytes[1] = shifted[15:8];
        job.bytes[2] = shifted[7:0];
        job.last     = in_last;
        if (in_last && is_pad) job.cnt = twp_r ? 2'd0 : 2'd1;
        else                   job.cnt = 2'd2;
        phase_nxt   = 2'd0;
        partial_nxt = '0;
        twp_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      alt_r       <= 1'b0;
      phase_r     <= 2'd0;
      partial_r   <= '0;
      twp_r       <= 1'b0;
      failed_r    <= 1'b0;
    end else if (cfg_we &&
                 (cfg_index == b64sc_pkg::REG_DIRECTION ||
                  cfg_index == b64sc_pkg::REG_ALT_ALPHABET)) begin
      if (cfg_index == b64sc_pkg::REG_DIRECTION) direction_r <= cfg_data;
      else                                       alt_r       <= cfg_data;
      phase_r   <= 2'd0;
      partial_r <= '0;
      twp_r     <= 1'b0;
      failed_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      twp_r     <= twp_nxt;
      failed_r  <= failed_nxt;
    end
  end

endmodule

// ----- rtl/b64sc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_queue: small group queue
// Register FIFO of result groups between the front and back ends.
// ----------------------------------------------------------------------------
module b64sc_queue #(
  parameter int unsigned DEPTH = b64sc_pkg::QUEUE_DEPTH  // 2..8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64sc_pkg::job_t wr_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output b64sc_pkg::job_t rd_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  b64sc_pkg::job_t  mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full      = (count_r == Full);
  assign not_empty = (count_r != '0);
  assign rd_job    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- rtl/b64sc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_back: result serializer
// Pops result groups and sends them out one beat per cycle while out_tready
// is high, through a registered output stage.
// ----------------------------------------------------------------------------
module b64sc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  b64sc_pkg::job_t q_job,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic [0:0]      out_tuser
);

  b64sc_pkg::job_t cur_r;
  logic            cur_valid_r;
  logic            out_valid_r;
  logic [7:0]      out_data_r;
  logic            out_last_r, out_err_r;
  logic            adv, done;

  assign adv   = cur_valid_r && (!out_valid_r || out_tready);
  assign done  = adv && (cur_r.cnt == 2'd0);
  assign q_pop = q_not_empty && (!cur_valid_r || done);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end else if (adv) begin
      cur_r.bytes <= {8'h00, cur_r.bytes[3:1]};
      cur_r.cnt   <= cur_r.cnt - 2'd1;
    end
    if (adv) begin
      out_data_r <= cur_r.bytes[0];
      out_last_r <= cur_r.last && (cur_r.cnt == 2'd0);
      out_err_r  <= cur_r.err && (cur_r.cnt == 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop)     cur_valid_r <= 1'b1;
      else if (done) cur_valid_r <= 1'b0;
      if (adv)             out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

endmodule

// ----- rtl/base64_stream_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder / decoder
// Byte stream in, character or byte stream out, mode set by register writes.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one byte per beat, in_tlast on the final byte of a message.
//  - out_*: one result per beat; out_tuser[0] flags an error result, which
//    carries zero data and out_tlast, and means the message is discarded.
//  - cfg_*: register 0 direction (0 encode, 1 decode), register 1 alphabet
//    (0 standard with '=' pad, 1 '_' '.' with '-' pad). Each write restarts
//    the message state. Write only while the block is drained.
//  - Path: a beat's first result passes through the queue write, the
//    serializer load and the output register before it shows on out_*.
//  - Throughput: the serializer sends one result per cycle while out_tready
//    is high, so encoding sustains four characters per three bytes and
//    decoding takes one character per cycle.
//  - A stalled out_tready holds the output register; the queue absorbs up to
//    QUEUE_DEPTH groups, then in_tready drops. cfg_ready is always high.
//  - Reset (rst_n low, synchronous) clears mode, message state and queue.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
  parameter int unsigned QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic                           out_tlast,
  output logic [0:0]                     out_tuser,  // [0] error
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [b64sc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic                           cfg_data
);

  logic            q_full, q_not_empty, q_pop, push, accept;
  b64sc_pkg::job_t job, q_job;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  b64sc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push),
    .job       (job)
  );

  b64sc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_job    (job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_job    (q_job)
  );

  b64sc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  // A group is never written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("group pushed into full queue");

  // An error group is a single closing result
  a_err_group: assert property (@(posedge clk) disable iff (!rst_n)
    (push && job.err) |-> (job.cnt == 2'd0 && job.last))
    else $error("malformed error group");

  // Error results carry zero data and close the message
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && out_tdata == 8'h00))
    else $error("bad error beat");

  // Pop only from a non-empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty) else $error("pop from empty queue");

endmodule
